### sv/cbm_pkg.sv
// Package for the cubic base multiplier: payload types, Plantard constants
// and the shared reduction function. Depends on nothing.

package cbm_pkg;

    // Payload types
    typedef logic signed [15:0] coef_t;
    typedef logic signed [11:0] res_t;
    typedef logic [31:0]        word_t;

    // Three-element bundles, index is the coefficient or pair number
    typedef logic [2:0][15:0]   coef3_t;
    typedef logic [2:0][31:0]   word3_t;

    // Modulus and premultiplied Plantard constants
    localparam int    MOD_Q   = 3457;
    localparam word_t QINV    = 32'h7456_3281;
    localparam word_t RC      = 32'h0012_F51E;
    localparam word_t RSQ     = 32'hBFCB_DDF0;
    localparam int    RND_ADD = 8;
    localparam int    HALF_SH = 16;

    // Number of lanes and pipeline stages inside one lane
    localparam int NUM_LANES   = 3;
    localparam int LANE_STAGES = 5;

    // Per lane, which of the three cross products land at degree three or
    // more and therefore wrap around through zeta.
    localparam logic [NUM_LANES-1:0][2:0] LANE_HI_MASK = '{3'b000, 3'b100, 3'b110};

    // Stage enables handed from the pipeline control to each lane.
    typedef struct packed {
        logic [LANE_STAGES-1:0] en;
    } lane_ctrl_t;

    // Plantard reduction: floor((signed high half + 8) * q / 2^16).
    function automatic res_t red(input word_t x);
        logic signed [16:0] h;
        logic signed [29:0] v;
        begin
            h = $signed({x[31], x[31:16]}) + 17'(RND_ADD);
            v = 30'(h) * 30'(MOD_Q);
            red = res_t'(v[HALF_SH+11:HALF_SH]);
        end
    endfunction

    // Sign-extend a 12-bit residue to a full word.
    function automatic word_t sext_res(input res_t r);
        sext_res = {{20{r[11]}}, r};
    endfunction

    // Sign-extend a 16-bit coefficient to a full word.
    function automatic word_t sext_coef(input logic [15:0] c);
        sext_coef = {{16{c[15]}}, c};
    endfunction

endpackage

### sv/cbm_in_if.sv
// Input channel of the cubic base multiplier: valid, ready, func and the operands.
// Depends on cbm_pkg for the payload types.

interface cbm_in_if;
    import cbm_pkg::*;

    logic         valid;
    logic         ready;
    logic         func;
    coef_t        coef_a0;
    coef_t        coef_a1;
    coef_t        coef_a2;
    coef_t        coef_b0;
    coef_t        coef_b1;
    coef_t        coef_b2;
    coef_t        addend_c0;
    coef_t        addend_c1;
    coef_t        addend_c2;
    word_t        twiddle;

    modport source (
        output valid, func, coef_a0, coef_a1, coef_a2, coef_b0, coef_b1, coef_b2,
               addend_c0, addend_c1, addend_c2, twiddle,
        input  ready
    );

    modport sink (
        input  valid, func, coef_a0, coef_a1, coef_a2, coef_b0, coef_b1, coef_b2,
               addend_c0, addend_c1, addend_c2, twiddle,
        output ready
    );
endinterface

### sv/cbm_out_if.sv
// Output channel of the cubic base multiplier: valid, ready and three residues.
// Depends on cbm_pkg for the payload types.

interface cbm_out_if;
    import cbm_pkg::*;

    logic valid;
    logic ready;
    res_t prod_r0;
    res_t prod_r1;
    res_t prod_r2;

    modport source (
        output valid, prod_r0, prod_r1, prod_r2,
        input  ready
    );

    modport sink (
        input  valid, prod_r0, prod_r1, prod_r2,
        output ready
    );
endinterface

### sv/cbm_lane.sv
// One coefficient lane of the cubic base multiplier: cross products, wrap
// through zeta and conversion products, five registered stages.
// Depends on cbm_pkg.

module cbm_lane (
    input  logic                clk,
    input  cbm_pkg::lane_ctrl_t ctrl,
    input  logic [2:0]          hi_mask,
    input  cbm_pkg::word3_t     a_pm,
    input  cbm_pkg::coef3_t     b_sel,
    input  cbm_pkg::coef_t      addend,
    input  cbm_pkg::word_t      zeta,
    output cbm_pkg::word_t      t_rsq,
    output cbm_pkg::word_t      c_rc
);
    import cbm_pkg::*;

    word3_t prod_reg;
    word_t  zeta1_reg, zeta2_reg;
    coef_t  c1_reg, c2_reg, c3_reg, c4_reg;
    res_t   s_reg;
    word_t  lo2_reg, lo3_reg;
    word_t  m_reg;
    res_t   t_reg;
    word_t  t_rsq_reg, c_rc_reg;

    word_t  hi_sum, lo_sum;

    // Stage one: the three cross products of this lane, modulo 2^32.
    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            for (int n = 0; n < 3; n++)
            begin
                prod_reg[n] <= a_pm[n] * sext_coef(b_sel[n]);
            end
            zeta1_reg <= zeta;
            c1_reg    <= addend;
        end
    end

    // Split the products into the part that wraps and the part that stays.
    always_comb
    begin
        hi_sum = '0;
        lo_sum = '0;
        for (int n = 0; n < 3; n++)
        begin
            if (hi_mask[n])
            begin
                hi_sum = hi_sum + prod_reg[n];
            end
            else
            begin
                lo_sum = lo_sum + prod_reg[n];
            end
        end
    end

    // Stage two: reduce the wrapping part.
    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            s_reg     <= red(hi_sum);
            lo2_reg   <= lo_sum;
            zeta2_reg <= zeta1_reg;
            c2_reg    <= c1_reg;
        end
    end

    // Stage three: multiply the wrapped residue by zeta.
    always_ff @(posedge clk)
    begin
        if (ctrl.en[2])
        begin
            m_reg   <= sext_res(s_reg) * zeta2_reg;
            lo3_reg <= lo2_reg;
            c3_reg  <= c2_reg;
        end
    end

    // Stage four: fold the wrapped term in and reduce.
    always_ff @(posedge clk)
    begin
        if (ctrl.en[3])
        begin
            t_reg  <= red(m_reg + lo3_reg);
            c4_reg <= c3_reg;
        end
    end

    // Stage five: conversion products for the final reduction.
    always_ff @(posedge clk)
    begin
        if (ctrl.en[4])
        begin
            t_rsq_reg <= sext_res(t_reg) * RSQ;
            c_rc_reg  <= sext_coef(c4_reg) * RC;
        end
    end

    assign t_rsq = t_rsq_reg;
    assign c_rc  = c_rc_reg;

endmodule

### sv/cubic_base_multiply.sv
// Top level of the cubic base multiplier: premultiply stage, three lanes,
// merging output stage and pipeline control. Depends on cbm_pkg, cbm_in_if,
// cbm_out_if and cbm_lane.

// The block multiplies two degree-2 polynomials modulo X^3 - zeta over Z_q,
// q = 3457, in Plantard form, and with func set adds an addend polynomial.
// It takes one word per clock cycle unless the pipe is full and the output
// is stalled. The word passes through seven register stages and is captured
// in the first of them at the accepting edge: the q^-1 premultiply, five
// stages per coefficient lane (cross products, wrap reduction, zeta product,
// fold and reduction, conversion products) and the merging stage that adds
// the addend term and does the last reduction. Each stage holds its word
// until the next stage has room, so empty stages fill up while the output is
// stalled and input keeps being taken until the pipe is full.
// Results are centered residues in -1729..1728.

module cubic_base_multiply (
    input  logic clk,
    input  logic rst_n,
    cbm_in_if.sink    req,
    cbm_out_if.source rsp
);
    import cbm_pkg::*;

    localparam int NSTAGE = LANE_STAGES + 2;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    word3_t a_pm_reg;
    coef3_t b_reg;
    coef_t  c_reg [NUM_LANES];
    word_t  zeta_reg;
    logic [LANE_STAGES:0] func_reg;

    coef3_t     b_rot [NUM_LANES];
    word_t      t_rsq [NUM_LANES];
    word_t      c_rc  [NUM_LANES];
    lane_ctrl_t lane_ctrl;
    res_t       r_reg [NUM_LANES];

    // A stage may load when it is empty or its word moves on.
    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || rsp.ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign req.ready    = en[0];
    assign lane_ctrl.en = en[LANE_STAGES:1];

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= req.valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Premultiply stage: each first-factor coefficient times q^-1.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_pm_reg[0] <= sext_coef(req.coef_a0) * QINV;
            a_pm_reg[1] <= sext_coef(req.coef_a1) * QINV;
            a_pm_reg[2] <= sext_coef(req.coef_a2) * QINV;
            b_reg[0]    <= req.coef_b0;
            b_reg[1]    <= req.coef_b1;
            b_reg[2]    <= req.coef_b2;
            c_reg[0]    <= req.addend_c0;
            c_reg[1]    <= req.addend_c1;
            c_reg[2]    <= req.addend_c2;
            zeta_reg    <= req.twiddle;
        end
    end

    // The mode bit travels alongside the lanes up to the merging stage.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            func_reg[0] <= req.func;
        end
        for (int k = 1; k <= LANE_STAGES; k++)
        begin
            if (en[k])
            begin
                func_reg[k] <= func_reg[k-1];
            end
        end
    end

    // Lanes: lane K pairs a_n with b_(K-n mod 3), so it sees every product
    // that lands at degree K or K+3.
    for (genvar gk = 0; gk < NUM_LANES; gk++)
    begin : g_lane
        for (genvar gn = 0; gn < 3; gn++)
        begin : g_rot
            assign b_rot[gk][gn] = b_reg[(gk - gn + 3) % 3];
        end

        cbm_lane u_lane (
            .clk     (clk),
            .ctrl    (lane_ctrl),
            .hi_mask (LANE_HI_MASK[gk]),
            .a_pm    (a_pm_reg),
            .b_sel   (b_rot[gk]),
            .addend  (c_reg[gk]),
            .zeta    (zeta_reg),
            .t_rsq   (t_rsq[gk]),
            .c_rc    (c_rc[gk])
        );
    end

    // Merging stage: add the addend term when asked and do the last reduction.
    always_ff @(posedge clk)
    begin
        if (en[NSTAGE-1])
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                if (func_reg[LANE_STAGES])
                begin
                    r_reg[k] <= red(c_rc[k] + t_rsq[k]);
                end
                else
                begin
                    r_reg[k] <= red(t_rsq[k]);
                end
            end
        end
    end

    assign rsp.valid   = valid_reg[NSTAGE-1];
    assign rsp.prod_r0 = r_reg[0];
    assign rsp.prod_r1 = r_reg[1];
    assign rsp.prod_r2 = r_reg[2];

endmodule
